/* src/tpp_pkg.sv */
package tpp_pkg;

  localparam int PointsPerRing = 324;
  localparam int ScreenWidth   = 128;
  localparam int ScreenHeight  = 64;

  localparam logic [31:0] NormBias  = 32'd3145728;
  localparam logic [31:0] DepthBase = 32'd10485760;
  localparam logic [31:0] TubeScale = 32'd6144;
  localparam logic [15:0] Unit      = 16'd1024;
  localparam logic [31:0] HalfW     = 32'(ScreenWidth / 2);
  localparam logic [31:0] HalfH     = 32'(ScreenHeight / 2);
  localparam logic [9:0]  LastIndex = 10'(PointsPerRing - 1);
  localparam logic [9:0]  RingDone  = 10'(PointsPerRing);

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

endpackage

/* src/tpp_div.sv */
module tpp_div (
  input  logic             clk,
  input  logic             rst,
  input  tpp_pkg::div_req_t req,
  output logic             busy,
  output logic [31:0]      quo
);

  logic [31:0] rem;
  logic [31:0] qbits;
  logic [31:0] dabs;
  logic [5:0]  count;
  logic        neg;
  logic [32:0] trial;
  logic [31:0] nabs;

  assign nabs  = req.num[31] ? (32'd0 - req.num) : req.num;
  assign trial = {rem, qbits[31]} - {1'b0, dabs};
  assign quo   = neg ? (32'd0 - qbits) : qbits;

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= 6'd32;
      rem   <= '0;
      qbits <= nabs;
      dabs  <= req.den[31] ? (32'd0 - req.den) : req.den;
      neg   <= req.num[31] ^ req.den[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem   <= trial[31:0];
        qbits <= {qbits[30:0], 1'b1};
      end else begin
        rem   <= {rem[30:0], qbits[31]};
        qbits <= {qbits[30:0], 1'b0};
      end
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* src/torus_point_projector.sv */
// Torus point generator. Each transfer on the input yields one point on the output.
// The block is ready for the next item in the same cycle that a finished point
// appears in the output register. One shared 32x32 multiplier is stepped through ten
// projection products and six ring rotation products, and the two perspective
// divisions each hold the sequencer in a bit-serial divider. When the projection depth
// is zero the divisions are skipped. A start item (op = 1) first runs 'frame' rotation
// pairs of the angle rotors, up to 1023 pairs. The block takes no item while busy; a
// finished point waits in the output register while the next item is accepted and
// computed, and apart from the divisions the sequencer stalls only when its next point
// is ready and the previous one has still not been taken.
module torus_point_projector (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [9:0] frame,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] pixel_x,
  output logic [5:0] pixel_y,
  output logic       visible,
  output logic       last
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ROT   = 5'd1;  // rotation micro steps
  localparam logic [4:0] S_P1    = 5'd2;
  localparam logic [4:0] S_P2    = 5'd3;
  localparam logic [4:0] S_P3    = 5'd4;
  localparam logic [4:0] S_P4    = 5'd5;
  localparam logic [4:0] S_P5    = 5'd6;
  localparam logic [4:0] S_P6    = 5'd7;
  localparam logic [4:0] S_P7    = 5'd8;
  localparam logic [4:0] S_P8    = 5'd9;
  localparam logic [4:0] S_P9    = 5'd10;
  localparam logic [4:0] S_DIVX  = 5'd11;
  localparam logic [4:0] S_WX    = 5'd12;
  localparam logic [4:0] S_DIVY  = 5'd13;
  localparam logic [4:0] S_WY    = 5'd14;
  localparam logic [4:0] S_FIN   = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  localparam logic [1:0] R_A    = 2'd0;
  localparam logic [1:0] R_B    = 2'd1;
  localparam logic [1:0] R_RING = 2'd2;

  logic [4:0]  state;
  logic [2:0]  rstep;
  logic [1:0]  rsel;
  logic [9:0]  frame_left;
  logic [15:0] sin_a, cos_a, sin_b, cos_b, ring_sin, ring_cos;
  logic [9:0]  point_count;
  logic [31:0] rx, ry, rn, t0, t1, x1, x3, x4, depth, nx, ny, qx;
  logic [31:0] mul_a, mul_b, prod;
  logic [63:0] prod_full;
  logic [15:0] rc, rs;
  logic [31:0] rsh;
  logic [31:0] sx, sy;
  logic        is_last;
  logic [6:0]  res_px;
  logic [5:0]  res_py;
  logic        res_vis;
  logic        res_last;
  logic        out_load;
  tpp_pkg::div_req_t dreq;
  logic        dbusy;
  logic [31:0] dquo;

  tpp_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quo(dquo));

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // Operands of the rotor under rotation.
  always_comb begin
    case (rsel)
      R_A:     begin rc = cos_a;    rs = sin_a;    end
      R_B:     begin rc = cos_b;    rs = sin_b;    end
      default: begin rc = ring_cos; rs = ring_sin; end
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_ROT) begin
      case (rstep)
        3'd0:    begin mul_a = 32'd5; mul_b = {{16{rs[15]}}, rs}; end
        3'd1:    begin mul_a = 32'd5; mul_b = {{16{rc[15]}}, rc}; end
        3'd2:    begin mul_a = rx;    mul_b = rx; end
        3'd3:    begin mul_a = ry;    mul_b = ry; end
        3'd4:    begin mul_a = rx;    mul_b = rn; end
        default: begin mul_a = ry;    mul_b = rn; end
      endcase
    end else begin
      case (state)
        S_P1: begin mul_a = {{16{ring_cos[15]}}, ring_cos}; mul_b = tpp_pkg::TubeScale; end
        S_P2: begin mul_a = {{16{ring_sin[15]}}, ring_sin}; mul_b = tpp_pkg::TubeScale; end
        S_P3: begin mul_a = {{16{sin_a[15]}}, sin_a}; mul_b = x3; end
        S_P4: begin mul_a = {{16{cos_a[15]}}, cos_a}; mul_b = x3; end
        S_P5: begin mul_a = {{16{cos_b[15]}}, cos_b}; mul_b = x1; end
        S_P6: begin mul_a = {{16{sin_b[15]}}, sin_b}; mul_b = x4; end
        S_P7: begin mul_a = {{16{cos_b[15]}}, cos_b}; mul_b = x4; end
        S_P8: begin mul_a = {{16{sin_b[15]}}, sin_b}; mul_b = x1; end
        S_P9: begin mul_a = tpp_pkg::HalfW; mul_b = t0; end
        S_DIVX: begin mul_a = tpp_pkg::HalfH; mul_b = t1; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign prod_full = mul_a * mul_b;
  assign prod      = prod_full[31:0];
  assign rsh       = (rsel == R_A) ? 32'($signed(prod) >>> 7) : 32'($signed(prod) >>> 8);
  assign sx        = tpp_pkg::HalfW + qx;
  assign sy        = tpp_pkg::HalfH + dquo;
  assign is_last   = (point_count + 10'd1) == tpp_pkg::LastIndex + 10'd1;

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = nx;
    dreq.den   = depth;
    if (state == S_DIVX && depth != '0) begin
      dreq.start = 1'b1;
    end else if (state == S_WX && !dbusy && depth != '0) begin
      dreq.start = 1'b1;
      dreq.num   = ny;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      sin_a       <= tpp_pkg::Unit;
      cos_a       <= '0;
      sin_b       <= tpp_pkg::Unit;
      cos_b       <= '0;
      ring_sin    <= '0;
      ring_cos    <= tpp_pkg::Unit;
      point_count <= '0;
      rstep       <= '0;
      rsel        <= R_A;
      frame_left  <= '0;
    end else begin
      out_valid <= out_load || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (op) begin
              sin_a <= tpp_pkg::Unit; cos_a <= '0;
              sin_b <= tpp_pkg::Unit; cos_b <= '0;
              ring_sin <= '0; ring_cos <= tpp_pkg::Unit; point_count <= '0;
              frame_left <= frame;
              rsel  <= R_A;
              rstep <= '0;
              state <= (frame == '0) ? S_P1 : S_ROT;
            end else begin
              if (point_count >= tpp_pkg::RingDone) begin
                ring_sin <= '0; ring_cos <= tpp_pkg::Unit; point_count <= '0;
              end
              state <= S_P1;
            end
          end
        end
        S_ROT: begin
          rstep <= rstep + 3'd1;
          case (rstep)
            3'd0: rx <= {{16{rc[15]}}, rc} - rsh;
            3'd1: ry <= {{16{rs[15]}}, rs} + rsh;
            3'd2: t0 <= tpp_pkg::NormBias - prod;
            3'd3: rn <= 32'($signed(t0 - prod) >>> 11);
            3'd4: t1 <= 32'($signed(prod) >>> 10);
            default: begin
              rstep <= '0;
              case (rsel)
                R_A: begin
                  cos_a <= t1[15:0];
                  sin_a <= prod[25:10];
                  rsel  <= R_B;
                end
                R_B: begin
                  cos_b <= t1[15:0];
                  sin_b <= prod[25:10];
                  rsel  <= R_A;
                  frame_left <= frame_left - 10'd1;
                  if (frame_left == 10'd1) begin
                    state <= S_P1;
                  end
                end
                default: begin
                  ring_cos <= t1[15:0];
                  ring_sin <= prod[25:10];
                  state    <= S_OUT;
                end
              endcase
            end
          endcase
        end
        S_P1: begin x1 <= 32'($signed(prod) >>> 10); state <= S_P2; end
        S_P2: begin x3 <= 32'($signed(prod) >>> 10); state <= S_P3; end
        S_P3: begin x4 <= 32'd0 - 32'($signed(prod) >>> 10); state <= S_P4; end
        S_P4: begin depth <= tpp_pkg::DepthBase + prod; state <= S_P5; end
        S_P5: begin t0 <= prod; state <= S_P6; end
        S_P6: begin t0 <= t0 - prod; state <= S_P7; end
        S_P7: begin t1 <= prod; state <= S_P8; end
        S_P8: begin t1 <= t1 + prod; state <= S_P9; end
        S_P9: begin nx <= prod; state <= S_DIVX; end
        S_DIVX: begin ny <= prod; state <= (depth == '0) ? S_FIN : S_WX; end
        S_WX: begin
          if (!dbusy) begin
            qx    <= dquo;
            state <= S_WY;
          end
        end
        S_WY: begin
          if (!dbusy) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          res_px  <= '0;
          res_py  <= '0;
          res_vis <= 1'b0;
          if (depth != '0 && !sx[31] && sx != '0 && $signed(sx) < tpp_pkg::ScreenWidth &&
              !sy[31] && sy != '0 && $signed(sy) < tpp_pkg::ScreenHeight) begin
            res_px  <= sx[6:0];
            res_py  <= sy[5:0];
            res_vis <= 1'b1;
          end
          res_last    <= is_last;
          point_count <= is_last ? tpp_pkg::RingDone : point_count + 10'd1;
          rsel        <= R_RING;
          rstep       <= '0;
          state       <= S_ROT;
        end
        S_OUT: begin
          // The new point moves out only once the previous one has been taken.
          if (out_load) begin
            pixel_x <= res_px;
            pixel_y <= res_py;
            visible <= res_vis;
            last    <= res_last;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/tpp_checker.sv */
module tpp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] pixel_x,
  input logic [5:0] pixel_y,
  input logic       visible
);

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> pixel_x == '0 && pixel_y == '0) else $error("hidden point nonzero");
  a_vis_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && visible |-> pixel_x != '0 && pixel_y != '0) else $error("visible on edge");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

bind torus_point_projector tpp_checker u_tpp_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .pixel_x(pixel_x),
  .pixel_y(pixel_y), .visible(visible)
);
